// ----- sv/het_pkg.sv -----
// Package for the hysteresis edge tracking block: sizes, pixel classes and register indexes.
// No dependencies; used by the top level and the testbench.
`timescale 1ns / 1ps
`default_nettype none
package het_pkg;
	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
	localparam int IDX_W      = $clog2(STORE_SIZE);
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int DIM_W      = 9;
	localparam int TOT_W      = IDX_W + 1;
	localparam int VAL_W      = 16;
	localparam int CFG_A_W    = 3;
	localparam int CLS_W      = 2;

	typedef logic [CLS_W-1:0] cls_t;
	localparam cls_t CLS_FAIL      = 2'd0;
	localparam cls_t CLS_SOFT_PASS = 2'd1;
	localparam cls_t CLS_PASS      = 2'd2;

	typedef enum logic [CFG_A_W-1:0] {
		REG_SOFT_THR = 3'd0,
		REG_HARD_THR = 3'd1,
		REG_PASS_VAL = 3'd2,
		REG_FAIL_VAL = 3'd3,
		REG_WIDTH    = 3'd4,
		REG_HEIGHT   = 3'd5
	} cfg_reg_t;
endpackage
`default_nettype wire

// ----- sv/het_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module het_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ----- sv/hysteresis_edge_tracking.sv -----
// Top level: hysteresis edge tracking with union-find over 4-connected pixels.
// Depends on het_pkg and het_ram.
// A load item (tuser 0) is written and, when it is not a fail pixel, checked
// against each neighbour that exists (left, then upper); for a non-fail
// neighbour the block walks parent links from the new pixel and from the
// neighbour to their roots and joins the two. A read item (tuser 1) walks
// parent links from the pixel to its root, and holds in its last step
// while the previous result item is still waiting.
// Every step is one read of the link and class RAMs through a single registered
// read port, so the link depth of the components sets the rate. Roots always
// take the lower index, so walks stay short for typical edge maps.
`timescale 1ns / 1ps
`default_nettype none
module hysteresis_edge_tracking (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic [het_pkg::VAL_W-1:0]   s_tdata,   // [15:0] pixel_value
	input  wire logic                        s_tuser,   // [0] mode
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic      [het_pkg::VAL_W-1:0]   m_tdata,   // [15:0] pixel_out
	output logic                             m_tlast,
	input  wire logic                        cfg_wen,
	input  wire logic [het_pkg::CFG_A_W-1:0] cfg_addr,
	input  wire logic [het_pkg::VAL_W-1:0]   cfg_wdata
);
	import het_pkg::*;

	typedef enum logic [2:0] {ST_IDLE, ST_WRITE, ST_ADV, ST_NCHK, ST_FIND, ST_JOIN} state_t;
	typedef enum logic [1:0] {ROLE_NEW, ROLE_NBR, ROLE_READ} role_t;

	state_t            state_q;
	role_t             role_q;
	logic [VAL_W-1:0]  soft_q, hard_q, pass_q, fail_q;
	logic [DIM_W-1:0]  width_q, height_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [IDX_W-1:0]  rpos_q;
	logic [IDX_W-1:0]  idx_q, nbr_q, cur_q, cur_d, ra_q;
	logic [DIM_W-1:0]  w_eff_q;
	cls_t              cls_q, sa_q;
	logic              pend_left_q, pend_up_q, last_q;
	logic              mvalid_q, mlast_q;
	logic [VAL_W-1:0]  mdata_q;

	logic [DIM_W-1:0]  w_eff, h_eff;
	logic [TOT_W-1:0]  total;
	logic [DIM_W-1:0]  col_eff, col_n, row_a, row_eff, row_n;
	logic [TOT_W-1:0]  idx_full, rnext;
	logic [IDX_W-1:0]  rp_eff;
	cls_t              cls_in;
	logic              acc, root_hit, out_free, out_load;
	logic [IDX_W-1:0   ] link_rd, link_wa, link_wd, lo, hi;
	cls_t              str_rd, str_wd, best;
	logic [IDX_W-1:0]  str_wa;
	logic              link_we, str_we;

	assign w_eff = (width_q == '0) ? DIM_W'(1) :
		(width_q > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_q;
	assign h_eff = (height_q == '0) ? DIM_W'(1) :
		(height_q > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_q;
	assign total = TOT_W'(w_eff * h_eff);

	assign col_eff  = ({1'b0, col_q} >= w_eff) ? '0 : {1'b0, col_q};
	assign row_a    = ({1'b0, col_q} >= w_eff) ? {1'b0, row_q} + DIM_W'(1) : {1'b0, row_q};
	assign row_eff  = (row_a >= h_eff) ? '0 : row_a;
	assign idx_full = TOT_W'(row_eff * w_eff) + TOT_W'(col_eff);
	assign col_n    = col_eff + DIM_W'(1);
	assign row_n    = (row_eff + DIM_W'(1) >= h_eff) ? '0 : row_eff + DIM_W'(1);

	assign cls_in = (s_tdata < soft_q) ? CLS_FAIL : (s_tdata < hard_q) ? CLS_SOFT_PASS : CLS_PASS;

	assign rp_eff = ({1'b0, rpos_q} >= total) ? '0 : rpos_q;
	assign rnext  = {1'b0, rp_eff} + TOT_W'(1);

	assign acc      = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign root_hit = (link_rd >= cur_q);
	assign out_free = !mvalid_q || m_tready;
	assign out_load = (state_q == ST_FIND) && (role_q == ROLE_READ) && root_hit && out_free;

	assign lo   = (ra_q < cur_q) ? ra_q : cur_q;
	assign hi   = (ra_q < cur_q) ? cur_q : ra_q;
	assign best = (sa_q > str_rd) ? sa_q : str_rd;

	// Read address follows the next walk position, so read data matches cur_q.
	always_comb begin
		cur_d = cur_q;
		unique case (state_q)
			ST_IDLE:  cur_d = (acc && s_tuser) ? rp_eff : cur_q;
			ST_ADV:   cur_d = pend_left_q ? idx_q - IDX_W'(1) : idx_q - IDX_W'(w_eff_q);
			ST_NCHK:  cur_d = idx_q;
			ST_FIND:  begin
				if (!root_hit) begin
					cur_d = link_rd;
				end else if (role_q == ROLE_NEW) begin
					cur_d = nbr_q;
				end
			end
			ST_WRITE, ST_JOIN: cur_d = cur_q;
			default:  cur_d = cur_q;
		endcase
	end

	always_comb begin
		link_we = 1'b0;
		str_we  = 1'b0;
		link_wa = idx_q;
		link_wd = idx_q;
		str_wa  = idx_q;
		str_wd  = cls_q;
		if (state_q == ST_WRITE) begin
			link_we = 1'b1;
			str_we  = 1'b1;
		end else if (state_q == ST_JOIN && ra_q != cur_q) begin
			link_we = 1'b1;
			str_we  = 1'b1;
			link_wa = hi;
			link_wd = lo;
			str_wa  = lo;
			str_wd  = best;
		end
	end

	het_ram #(.WIDTH(IDX_W), .DEPTH(STORE_SIZE)) u_link_ram (
		.clk(clk), .we(link_we), .waddr(link_wa), .wdata(link_wd),
		.raddr(cur_d), .rdata(link_rd)
	);

	het_ram #(.WIDTH(CLS_W), .DEPTH(STORE_SIZE)) u_class_ram (
		.clk(clk), .we(str_we), .waddr(str_wa), .wdata(str_wd),
		.raddr(cur_d), .rdata(str_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			role_q      <= ROLE_NEW;
			soft_q      <= '0;
			hard_q      <= '1;
			pass_q      <= '1;
			fail_q      <= '0;
			width_q     <= DIM_W'(MAX_WIDTH);
			height_q    <= DIM_W'(MAX_HEIGHT);
			col_q       <= '0;
			row_q       <= '0;
			rpos_q      <= '0;
			pend_left_q <= 1'b0;
			pend_up_q   <= 1'b0;
			mvalid_q    <= 1'b0;
			cur_q       <= '0;
			idx_q       <= '0;
			nbr_q       <= '0;
			ra_q        <= '0;
			w_eff_q     <= '0;
			cls_q       <= CLS_FAIL;
			sa_q        <= CLS_FAIL;
			last_q      <= 1'b0;
			mlast_q     <= 1'b0;
			mdata_q     <= '0;
		end else begin
			cur_q <= cur_d;
			if (out_load) begin
				mvalid_q <= 1'b1;
				mdata_q  <= (str_rd == CLS_PASS) ? pass_q : fail_q;
				mlast_q  <= last_q;
			end else if (mvalid_q && m_tready) begin
				mvalid_q <= 1'b0;
			end
			if (cfg_wen) begin
				unique case (cfg_addr)
					REG_SOFT_THR: soft_q   <= cfg_wdata;
					REG_HARD_THR: hard_q   <= cfg_wdata;
					REG_PASS_VAL: pass_q   <= cfg_wdata;
					REG_FAIL_VAL: fail_q   <= cfg_wdata;
					REG_WIDTH:    width_q  <= cfg_wdata[DIM_W-1:0];
					REG_HEIGHT:   height_q <= cfg_wdata[DIM_W-1:0];
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc && s_tuser) begin
						role_q  <= ROLE_READ;
						last_q  <= ({1'b0, rp_eff} == total - TOT_W'(1));
						rpos_q  <= (rnext >= total) ? '0 : rnext[IDX_W-1:0];
						state_q <= ST_FIND;
					end else if (acc) begin
						idx_q       <= idx_full[IDX_W-1:0];
						cls_q       <= cls_in;
						w_eff_q     <= w_eff;
						pend_left_q <= (cls_in != CLS_FAIL) && (col_eff != '0);
						pend_up_q   <= (cls_in != CLS_FAIL) && (row_eff != '0);
						if (col_n >= w_eff) begin
							col_q <= '0;
							row_q <= row_n[ROW_W-1:0];
						end else begin
							col_q <= col_n[COL_W-1:0];
							row_q <= row_eff[ROW_W-1:0];
						end
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE, ST_JOIN: state_q <= ST_ADV;
				ST_ADV: begin
					if (pend_left_q) begin
						pend_left_q <= 1'b0;
						nbr_q       <= cur_d;
						state_q     <= ST_NCHK;
					end else if (pend_up_q) begin
						pend_up_q <= 1'b0;
						nbr_q     <= cur_d;
						state_q   <= ST_NCHK;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_NCHK: begin
					role_q  <= ROLE_NEW;
					state_q <= (str_rd != CLS_FAIL) ? ST_FIND : ST_ADV;
				end
				ST_FIND: begin
					if (root_hit) begin
						unique case (role_q)
							ROLE_NEW: begin
								ra_q   <= cur_q;
								sa_q   <= str_rd;
								role_q <= ROLE_NBR;
							end
							ROLE_NBR: state_q <= ST_JOIN;
							ROLE_READ: begin
								if (out_free) begin
									state_q <= ST_IDLE;
								end
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = mvalid_q;
	assign m_tdata  = mdata_q;
	assign m_tlast  = mlast_q;

	a_walk_descends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIND && !root_hit) |=> (cur_q < $past(cur_q)))
		else $error("root walk did not descend");
	a_load_writes: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && !s_tuser) |=> (state_q == ST_WRITE))
		else $error("load item did not reach the write step");
	a_out_from_find: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(mvalid_q) |-> ($past(state_q) == ST_FIND && $past(role_q) == ROLE_READ))
		else $error("result raised outside a readout walk");
	a_join_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_JOIN && link_we) |-> (hi > lo))
		else $error("union links a root to itself or upward");
endmodule
`default_nettype wire

// ----- tb/tb_hysteresis_edge_tracking.sv -----
// Self-checking testbench for hysteresis_edge_tracking: loads frames of strengths,
// reads them back and compares each result item with a union-find predictor.
// Depends on het_pkg and the RTL of the block.
`timescale 1ns / 1ps
`default_nettype none
module tb_hysteresis_edge_tracking;
	import het_pkg::*;

	localparam int LIMIT_CYCLES = 3000000;
	localparam int SETTLE       = 3000;
	localparam bit MODE_LOAD    = 1'b0;
	localparam bit MODE_READ    = 1'b1;

	class het_scoreboard;
		bit [IDX_W-1:0] parent [STORE_SIZE];
		cls_t           klass  [STORE_SIZE];
		int unsigned    col, row, rd_pos;
		bit [15:0]      soft_thr, hard_thr, pass_val, fail_val;
		bit [8:0]       width_reg, height_reg;
		bit [16:0]      exp_q[$];
		int             errors;

		function new();
			col = 0; row = 0; rd_pos = 0;
			soft_thr = 16'h0000; hard_thr = 16'hFFFF; pass_val = 16'hFFFF; fail_val = 16'h0000;
			width_reg = 9'd256; height_reg = 9'd256; errors = 0;
		endfunction

		function int unsigned eff(bit [8:0] v, int unsigned maxv);
			if (v == 0) return 1;
			if (v > maxv) return maxv;
			return v;
		endfunction

		function void write_reg(cfg_reg_t r, bit [15:0] d);
			case (r)
				REG_SOFT_THR: soft_thr = d;
				REG_HARD_THR: hard_thr = d;
				REG_PASS_VAL: pass_val = d;
				REG_FAIL_VAL: fail_val = d;
				REG_WIDTH:    width_reg = d[8:0];
				REG_HEIGHT:   height_reg = d[8:0];
				default: ;
			endcase
		endfunction

		function int unsigned root_of(int unsigned i);
			int unsigned nxt;
			while (parent[i] != i) begin
				nxt = parent[i];
				if (nxt > i) break;
				i = nxt;
			end
			return i;
		endfunction

		function void merge(int unsigned a, int unsigned b);
			int unsigned ra, rb, lo, hi;
			cls_t best;
			ra = root_of(a);
			rb = root_of(b);
			if (ra == rb) return;
			lo = (ra < rb) ? ra : rb;
			hi = (ra < rb) ? rb : ra;
			best = (klass[ra] > klass[rb]) ? klass[ra] : klass[rb];
			parent[hi] = IDX_W'(lo);
			klass[lo] = best;
		endfunction

		function void note_item(bit mode, bit [15:0] v);
			int unsigned w, h, total, idx, rt;
			cls_t c;
			w = eff(width_reg, MAX_WIDTH);
			h = eff(height_reg, MAX_HEIGHT);
			total = w * h;
			if (mode == MODE_LOAD) begin
				if (col >= w) begin col = 0; row++; end
				if (row >= h) row = 0;
				idx = row * w + col;
				if (v < soft_thr) c = CLS_FAIL;
				else if (v < hard_thr) c = CLS_SOFT_PASS;
				else c = CLS_PASS;
				parent[idx] = IDX_W'(idx);
				klass[idx] = c;
				if (c != CLS_FAIL) begin
					if (col > 0 && klass[idx-1] != CLS_FAIL) merge(idx, idx - 1);
					if (row > 0 && klass[idx-w] != CLS_FAIL) merge(idx, idx - w);
				end
				col++;
				if (col >= w) begin
					col = 0;
					row++;
					if (row >= h) row = 0;
				end
			end else begin
				if (rd_pos >= total) rd_pos = 0;
				rt = root_of(rd_pos);
				exp_q.push_back({rd_pos == total - 1,
					(klass[rt] == CLS_PASS) ? pass_val : fail_val});
				rd_pos++;
				if (rd_pos >= total) rd_pos = 0;
			end
		endfunction

		function void check_result(bit [15:0] data, bit last);
			bit [16:0] e;
			if (exp_q.size() == 0) begin
				$display("%0t: unexpected result item data=%h last=%b", $time, data, last);
				errors++;
				return;
			end
			e = exp_q.pop_front();
			if (e[15:0] !== data) begin
				$display("%0t: pixel_out expected %h actual %h", $time, e[15:0], data);
				errors++;
			end
			if (e[16] !== last) begin
				$display("%0t: last expected %b actual %b", $time, e[16], last);
				errors++;
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [VAL_W-1:0]  s_tdata;   // [15:0] pixel_value
	logic              s_tuser;   // [0] mode
	logic              m_tvalid;
	logic              m_tready;
	logic [VAL_W-1:0]  m_tdata;   // [15:0] pixel_out
	logic              m_tlast;
	logic              cfg_wen;
	logic [CFG_A_W-1:0] cfg_addr;
	logic [VAL_W-1:0]  cfg_wdata;

	het_scoreboard sb;
	int unsigned   n_loads, n_reads, n_frames, n_results, cycles;
	bit            hold_done;
	bit [15:0]     cur_soft, cur_hard;

	hysteresis_edge_tracking dut (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycles);
			$display("end of test: mismatches");
			$finish;
		end
		if (m_tvalid && m_tready) begin
			sb.check_result(m_tdata, m_tlast);
			n_results <= n_results + 1;
		end
	end

	// receiver: random stalls, one long hold while the sender keeps offering
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			int unsigned gap;
			gap = $urandom_range(0, 8);
			if ($urandom_range(0, 3) == 0) gap = 0;
			if (!hold_done && n_loads + n_reads > 400) begin
				hold_done = 1'b1;
				gap = 4000;
			end
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	task automatic send_item(bit mode, bit [15:0] v, bit burst);
		int unsigned gap;
		gap = burst ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= v;
		do @(posedge clk); while (!s_tready);
		sb.note_item(mode, v);
		if (mode == MODE_LOAD) n_loads++;
		else n_reads++;
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (sb.exp_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// hold the write enable from one register to the next; drop it with cfg_done
	task automatic write_reg(cfg_reg_t r, bit [15:0] d);
		cfg_wen   <= 1'b1;
		cfg_addr  <= r;
		cfg_wdata <= d;
		@(posedge clk);
		sb.write_reg(r, d);
	endtask

	task automatic cfg_done();
		cfg_wen <= 1'b0;
	endtask

	function automatic bit [15:0] pick_strength();
		int unsigned k;
		k = $urandom_range(0, 99);
		if (k < 5) return 16'h0000;
		if (k < 10) return 16'hFFFF;
		if (k < 40 && cur_soft > 0) return 16'($urandom_range(0, cur_soft - 1));
		if (k < 85) return 16'($urandom_range(cur_soft, 16'hFFFF));
		if (k < 97) return 16'($urandom_range(cur_hard, 16'hFFFF));
		return 16'($urandom);
	endfunction

	// loads and reads of one frame interleaved; a read never passes the loads
	task automatic run_frame(int unsigned total, bit burst);
		int unsigned loaded, readn;
		loaded = 0;
		readn = 0;
		while (loaded < total || readn < total) begin
			if (loaded < total && (readn >= loaded || $urandom_range(0, 2) != 0)) begin
				send_item(MODE_LOAD, pick_strength(), burst);
				loaded++;
			end else begin
				send_item(MODE_READ, 16'($urandom), burst);
				readn++;
			end
		end
		n_frames++;
	endtask

	task automatic run_phase(bit [15:0] soft_lvl, bit [15:0] hard_lvl, bit [15:0] pv,
		bit [15:0] fv, bit [8:0] wr, bit [8:0] hr, int unsigned frames);
		int unsigned total;
		wait_idle();
		write_reg(REG_SOFT_THR, soft_lvl);
		write_reg(REG_HARD_THR, hard_lvl);
		write_reg(REG_PASS_VAL, pv);
		write_reg(REG_FAIL_VAL, fv);
		write_reg(REG_WIDTH, {7'd0, wr});
		write_reg(REG_HEIGHT, {7'd0, hr});
		cfg_done();
		cur_soft = soft_lvl;
		cur_hard = hard_lvl;
		total = sb.eff(wr, MAX_WIDTH) * sb.eff(hr, MAX_HEIGHT);
		repeat (frames) run_frame(total, $urandom_range(0, 3) == 0);
	endtask

	initial begin
		int unsigned w, h;
		sb = new();
		cycles = 0; n_loads = 0; n_reads = 0; n_frames = 0; n_results = 0;
		hold_done = 1'b0;
		cur_soft = 16'h0000; cur_hard = 16'hFFFF;
		arst_n = 1'b0;
		s_tvalid = 1'b0; s_tdata = '0; s_tuser = 1'b0;
		cfg_wen = 1'b0; cfg_addr = REG_SOFT_THR; cfg_wdata = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: tiny frames, extreme thresholds, zero and oversize dimensions
		wait_idle();
		write_reg(REG_SOFT_THR, 16'h1000);
		write_reg(REG_HARD_THR, 16'h8000);
		write_reg(REG_PASS_VAL, 16'hFFFF);
		write_reg(REG_FAIL_VAL, 16'h0000);
		write_reg(REG_WIDTH, 16'd2);
		write_reg(REG_HEIGHT, 16'd2);
		cfg_done();
		send_item(MODE_LOAD, 16'h0000, 1'b0);
		send_item(MODE_LOAD, 16'h1000, 1'b0);
		send_item(MODE_LOAD, 16'h7FFF, 1'b0);
		send_item(MODE_READ, 16'hFFFF, 1'b0);
		send_item(MODE_LOAD, 16'hFFFF, 1'b0);
		repeat (4) send_item(MODE_READ, 16'h0000, 1'b0);
		run_phase(16'h0000, 16'h0000, 16'hAAAA, 16'h5555, 9'd0, 9'd0, 2);
		run_phase(16'hFFFF, 16'hFFFF, 16'h0001, 16'hFFFE, 9'd3, 9'd1, 1);
		run_phase(16'h8000, 16'h4000, 16'h00FF, 16'hFF00, 9'd511, 9'd1, 1);
		run_phase(16'h2000, 16'hE000, 16'hFFFF, 16'h0000, 9'd1, 9'd256, 1);

		// random: mostly small frames, occasionally the largest edge lengths
		while (n_loads + n_reads < 1900) begin
			w = $urandom_range(1, 12);
			h = $urandom_range(1, 12);
			if ($urandom_range(0, 15) == 0) begin
				w = $urandom_range(0, 1) ? 256 : $urandom_range(257, 511);
				h = 1;
			end
			run_phase(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
				9'(w), 9'(h), $urandom_range(1, 3));
		end

		wait_idle();
		$display("covered %0d loads and %0d reads over %0d frames, %0d result items checked",
			n_loads, n_reads, n_frames, n_results);
		if (sb.errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end
endmodule
`default_nettype wire
